### sv/prefill_token_budget_scheduler_defines.svh
`ifndef PREFILL_TOKEN_BUDGET_SCHEDULER_DEFINES_SVH
`define PREFILL_TOKEN_BUDGET_SCHEDULER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define PBTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define PBTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/pbts_pkg.sv
`timescale 1ns / 1ps

package pbts_pkg;

  localparam int TOKEN_BITS = 23;
  localparam int IN_W       = TOKEN_BITS + 1;
  localparam int MAX_SLOTS  = 64;
  localparam int SLOT_W     = 6;
  localparam int SCNT_W     = 7;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;

  // shared divider
  localparam int DIV_W      = IN_W;
  localparam int DIV_STEP_W = $clog2(DIV_W + 1);

  localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GRANT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SLOT  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SCHED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MICRO_BATCH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]       cmd;
    logic signed [IN_W-1:0] budget_tokens;
    logic signed [IN_W-1:0] decode_count;
    logic signed [IN_W-1:0] pending_count;
    logic signed [IN_W-1:0] requested_tokens;
    logic                   splittable;
    logic signed [IN_W-1:0] batch_used;
    logic [SLOT_W-1:0]      slot_offset;
    logic [SLOT_W-1:0]      scheduled_slot;
    logic signed [IN_W-1:0] scheduled_tokens;
  } in_item_t;

  typedef struct packed {
    logic [TOKEN_BITS-1:0] granted_tokens;
    logic                  exclusive_ok;
    logic [TOKEN_BITS-1:0] limit_tokens;
    logic [SLOT_W-1:0]     round_start;
    logic [SLOT_W-1:0]     slot_index;
  } out_item_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage

### sv/prefill_token_budget_scheduler.sv
`timescale 1ns / 1ps
`include "prefill_token_budget_scheduler_defines.svh"
// prefill token budget scheduler with a round-robin slot pointer
// input channel in_valid/in_ready carries one command word, output channel
// out_valid/out_ready returns exactly one result word per command, in order
// commands: begin round, grant query, slot at offset, scheduled notice
// config: cfg_we/cfg_index/cfg_wdata write the chunk limit, micro batch and
// slot count, one register per cycle; the user must write them only while
// the block is idle, which the block itself does not enforce; all divisions
// and slot modulos share one restoring divider, one bit a cycle
// sequencer states from the accepted command to the result word: grant
// query issue, done; slot at offset and scheduled notice issue, modulo
// (7-bit modulo by slot count) when needed, done; begin round issue,
// modulo unless slot count is zero, limit, fair share division (24 bits)
// when it runs, done
// in_ready comes back together with out_valid, so a command is taken only
// after the previous result has entered the output register; in_ready is
// also high while the previous result still waits in the output register
// a stalled receiver holds that result and the sequencer waits in its last
// state; synchronous reset clears the pointers and round state, restores
// the register defaults and empties the output register
module prefill_token_budget_scheduler (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  pbts_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output pbts_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [pbts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pbts_pkg::TOKEN_BITS-1:0]   cfg_wdata
);
  import pbts_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ISSUE = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_LIMIT = 3'd3;
  localparam logic [2:0] ST_FAIR  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  function automatic logic [TOKEN_BITS-1:0] left_after(
    input logic [TOKEN_BITS-1:0] budget,
    input logic signed [IN_W-1:0] used
  );
    logic [TOKEN_BITS-1:0] left;
    left = '0;
    if (budget != '0 && $signed({1'b0, budget}) > used) begin
      left = used[IN_W-1] ? budget : budget - used[TOKEN_BITS-1:0];
    end
    return left;
  endfunction

  function automatic logic [TOKEN_BITS-1:0] clamp0(input logic signed [IN_W-1:0] v);
    return v[IN_W-1] ? '0 : v[TOKEN_BITS-1:0];
  endfunction

  function automatic logic [TOKEN_BITS-1:0] umin(
    input logic [TOKEN_BITS-1:0] a,
    input logic [TOKEN_BITS-1:0] b
  );
    return (a < b) ? a : b;
  endfunction

  logic [2:0]            state;
  in_item_t              item;

  logic [TOKEN_BITS-1:0] chunk_limit;
  logic [TOKEN_BITS-1:0] micro_batch;
  logic [SCNT_W-1:0]     slot_count;

  logic [SLOT_W-1:0]     next_slot;
  logic [SLOT_W-1:0]     start_slot_reg;
  logic [TOKEN_BITS-1:0] round_budget;
  logic [TOKEN_BITS-1:0] round_decode;
  logic [TOKEN_BITS-1:0] round_pending;
  logic [TOKEN_BITS-1:0] round_limit;

  logic [TOKEN_BITS-1:0] res_granted;
  logic                  res_excl;
  logic [SLOT_W-1:0]     res_sidx;

  // divider hookup
  div_req_t              div_req;
  div_rsp_t              div_rsp;
  logic [DIV_W-1:0]      div_dividend;
  logic [DIV_W-1:0]      div_divisor;
  logic [DIV_W-1:0]      div_quo;
  logic [DIV_W-1:0]      div_rem;

  logic [SCNT_W-1:0]     n_eff;
  logic                  n_zero;
  logic                  toks_pos;
  logic                  need_mod;
  logic [SCNT_W-1:0]     mod_src;

  logic signed [IN_W-1:0] req;
  logic signed [IN_W-1:0] used;
  logic                  req_pos;
  logic [TOKEN_BITS-1:0] req_u;
  logic [TOKEN_BITS-1:0] avail_g;
  logic [TOKEN_BITS-1:0] grant_calc;
  logic                  excl_calc;

  logic [TOKEN_BITS-1:0] avail_r;
  logic [TOKEN_BITS-1:0] pb_eff;
  logic                  need_fair;
  logic [TOKEN_BITS-1:0] limit_direct;
  logic [TOKEN_BITS-1:0] fair_q;
  logic [TOKEN_BITS-1:0] fair_max;
  logic [TOKEN_BITS-1:0] fair_limit;
  logic                  out_free;

  assign n_eff    = (slot_count > SCNT_W'(MAX_SLOTS)) ? SCNT_W'(MAX_SLOTS) : slot_count;
  assign n_zero   = (n_eff == '0);
  assign toks_pos = !item.scheduled_tokens[IN_W-1] && (item.scheduled_tokens != '0);

  always_comb begin
    case (item.cmd)
      CMD_BEGIN: begin
        mod_src  = {1'b0, next_slot};
        need_mod = !n_zero;
      end
      CMD_SLOT: begin
        mod_src  = {1'b0, start_slot_reg} + {1'b0, item.slot_offset};
        need_mod = !n_zero;
      end
      CMD_SCHED: begin
        mod_src  = {1'b0, item.scheduled_slot} + SCNT_W'(1);
        need_mod = !n_zero && toks_pos;
      end
      default: begin
        mod_src  = '0;
        need_mod = 1'b0;
      end
    endcase
  end

  // grant query
  assign req     = item.requested_tokens;
  assign used    = item.batch_used;
  assign req_pos = !req[IN_W-1] && (req != '0);
  assign req_u   = req[TOKEN_BITS-1:0];
  assign avail_g = left_after(round_budget, used);

  always_comb begin
    grant_calc = '0;
    if (req_pos && avail_g != '0) begin
      if (item.splittable) begin
        grant_calc = umin(umin(req_u, avail_g), round_limit);
      end else begin
        grant_calc = (req_u <= avail_g) ? req_u : '0;
      end
    end
  end

  assign excl_calc = (round_decode == '0) && (round_pending == TOKEN_BITS'(1)) && req_pos
                   && (used == '0) && (round_budget != '0)
                   && (req_u <= round_budget || round_limit == round_budget);

  // round limit
  assign avail_r   = left_after(round_budget, {1'b0, round_decode});
  assign pb_eff    = (micro_batch == '0) ? TOKEN_BITS'(1) : micro_batch;
  assign need_fair = (avail_r != '0) && (chunk_limit == '0) && (round_decode == '0)
                   && (round_pending > TOKEN_BITS'(1));

  always_comb begin
    if (avail_r == '0) begin
      limit_direct = '0;
    end else if (chunk_limit != '0) begin
      limit_direct = umin(chunk_limit, avail_r);
    end else if (round_decode != '0) begin
      limit_direct = umin(avail_r, pb_eff);
    end else begin
      limit_direct = avail_r;
    end
  end

  assign fair_q     = div_quo[TOKEN_BITS-1:0];
  assign fair_max   = (pb_eff > fair_q) ? pb_eff : fair_q;
  assign fair_limit = umin(avail_r, fair_max);

  always_comb begin
    div_req.start = 1'b0;
    div_req.steps = DIV_STEP_W'(SCNT_W);
    div_dividend  = {mod_src, {(DIV_W-SCNT_W){1'b0}}};
    div_divisor   = {{(DIV_W-SCNT_W){1'b0}}, n_eff};
    case (state)
      ST_ISSUE: begin
        div_req.start = need_mod;
      end
      ST_LIMIT: begin
        // ceiling of avail over pending
        div_req.start = need_fair;
        div_req.steps = DIV_STEP_W'(DIV_W);
        div_dividend  = {1'b0, avail_r} + {1'b0, round_pending} - DIV_W'(1);
        div_divisor   = {1'b0, round_pending};
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  pbts_div u_div (
    .clk       (clk),
    .rst       (rst),
    .div_req   (div_req),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .div_rsp   (div_rsp),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_limit <= '0;
      micro_batch <= TOKEN_BITS'(512);
      slot_count  <= SCNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHUNK_LIMIT: chunk_limit <= cfg_wdata;
        REG_MICRO_BATCH: micro_batch <= cfg_wdata;
        REG_SLOT_COUNT:  slot_count  <= cfg_wdata[SCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      next_slot      <= '0;
      start_slot_reg <= '0;
      round_budget   <= '0;
      round_decode   <= '0;
      round_pending  <= '0;
      round_limit    <= '0;
    end else begin
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            item  <= in_data;
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          res_granted <= (item.cmd == CMD_GRANT) ? grant_calc : '0;
          res_excl    <= (item.cmd == CMD_GRANT) ? excl_calc : 1'b0;
          res_sidx    <= '0;
          if (item.cmd == CMD_BEGIN) begin
            round_budget  <= clamp0(item.budget_tokens);
            round_decode  <= clamp0(item.decode_count);
            round_pending <= clamp0(item.pending_count);
            round_limit   <= '0;
            if (n_zero) begin
              start_slot_reg <= '0;
            end
          end
          if (need_mod) begin
            state <= ST_MOD;
          end else if (item.cmd == CMD_BEGIN) begin
            state <= ST_LIMIT;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_MOD: begin
          if (div_rsp.done) begin
            case (item.cmd)
              CMD_BEGIN: begin
                start_slot_reg <= div_rem[SLOT_W-1:0];
                state          <= ST_LIMIT;
              end
              CMD_SLOT: begin
                res_sidx <= div_rem[SLOT_W-1:0];
                state    <= ST_DONE;
              end
              CMD_SCHED: begin
                next_slot <= div_rem[SLOT_W-1:0];
                state     <= ST_DONE;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_LIMIT: begin
          if (need_fair) begin
            state <= ST_FAIR;
          end else begin
            round_limit <= limit_direct;
            state       <= ST_DONE;
          end
        end
        ST_FAIR: begin
          if (div_rsp.done) begin
            round_limit <= fair_limit;
            state       <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_data.granted_tokens <= res_granted;
      out_data.exclusive_ok   <= res_excl;
      out_data.limit_tokens   <= round_limit;
      out_data.round_start    <= start_slot_reg;
      out_data.slot_index     <= res_sidx;
    end
  end

  `PBTS_ASSERT_NEXT(a_div_launch, state == ST_ISSUE && div_req.start, div_rsp.busy,
    "divider not running after launch")
  `PBTS_ASSERT_NOW(a_limit_in_budget, 1'b1, round_limit <= round_budget,
    "round limit above round budget")
  `PBTS_ASSERT_NOW(a_excl_has_limit, out_valid && out_data.exclusive_ok,
    out_data.limit_tokens != '0, "exclusive word with a zero round limit")
  `PBTS_ASSERT_NOW(a_div_while_wait, state == ST_FAIR,
    div_rsp.busy || div_rsp.done, "fair share wait without divider activity")

endmodule

### sv/pbts_div.sv
`timescale 1ns / 1ps
`include "prefill_token_budget_scheduler_defines.svh"

module pbts_div (
  input  logic                           clk,
  input  logic                           rst,
  input  pbts_pkg::div_req_t             div_req,
  input  logic [pbts_pkg::DIV_W-1:0]     dividend,
  input  logic [pbts_pkg::DIV_W-1:0]     divisor,
  output pbts_pkg::div_rsp_t             div_rsp,
  output logic [pbts_pkg::DIV_W-1:0]     quotient,
  output logic [pbts_pkg::DIV_W-1:0]     remainder
);
  import pbts_pkg::*;

  logic                  busy;
  logic                  done;
  logic [DIV_STEP_W-1:0] cnt;
  logic [DIV_W-1:0]      dvd;
  logic [DIV_W-1:0]      dsr;
  logic [DIV_W-1:0]      rem;
  logic [DIV_W-1:0]      quo;

  logic [DIV_W:0]        trial;
  logic [DIV_W:0]        diff;
  logic                  ge;

  // one quotient bit per cycle, restoring
  assign trial = {rem, dvd[DIV_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (div_req.start) begin
        busy <= 1'b1;
        cnt  <= div_req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_req.start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      dvd <= {dvd[DIV_W-2:0], 1'b0};
      rem <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo <= {quo[DIV_W-2:0], ge};
    end
  end

  assign div_rsp.busy = busy;
  assign div_rsp.done = done;
  assign quotient     = quo;
  assign remainder    = rem;

  `PBTS_ASSERT_NOW(a_div_no_restart, div_req.start, !busy, "divider started while busy")
  `PBTS_ASSERT_NOW(a_div_done_idle, done, !busy, "divider done while still busy")

endmodule
